>>> rtl/aip_pkg.sv
package aip_pkg;

	// default sizes of the table
	localparam int DEF_ENTRIES    = 16;
	localparam int DEF_ID_WIDTH   = 16;
	localparam int DEF_TIME_WIDTH = 32;

	// fixed port widths
	localparam int TOL_W      = 16;
	localparam int PORT_ID_W  = 16;
	localparam int PORT_NOW_W = 32;

	// tolerance scaling, milliseconds to microseconds
	localparam int US_PER_MS = 1000;
	localparam int LIMIT_W   = TOL_W + 10;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(250);

	typedef logic [1:0] status_t;

	localparam status_t RPT_NONE    = 2'd0;
	localparam status_t RPT_REFRESH = 2'd1;
	localparam status_t RPT_INSERT  = 2'd2;
	localparam status_t RPT_DROP    = 2'd3;

	localparam logic CMD_REPORT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

endpackage

>>> rtl/aging_id_presence_table.sv
// channel | direction | beat contents                          | handshake
// --------+-----------+----------------------------------------+---------------------
// cfg     | in        | cfg_data (tolerance in ms)             | cfg_valid / cfg_ready
// in      | in        | cmd, now_us, mote_id, query_id         | in_valid / in_ready
// out     | out       | confirmed, report_status               | out_valid / out_ready
//
// every item scans the whole table through the single read port of the id/time memories:
// the item is accepted in idle, the scan state reads and compares every entry, and the
// update state writes back; the next item is taken only after the update.
// reset clears the per-entry occupancy flops at once, no clearing pass is needed,
// and loads the tolerance with 250 ms.
// a result waiting in the output register does not block the next input beat; only
// the update cycle holds while the output register is still full.
module aging_id_presence_table
	import aip_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_ENTRIES,
	parameter int ID_WIDTH      = DEF_ID_WIDTH,
	parameter int TIME_WIDTH    = DEF_TIME_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [TOL_W-1:0]      cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [PORT_NOW_W-1:0] now_us,
	input  logic [PORT_ID_W-1:0]  mote_id,
	input  logic [PORT_ID_W-1:0]  query_id,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  confirmed,
	output status_t               report_status
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	// entry storage, occupancy lives in flops so reset is immediate
	logic [ID_WIDTH-1:0]   id_mem   [TABLE_ENTRIES];
	logic [TIME_WIDTH-1:0] time_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TOL_W-1:0]      tolerance_ms_q;

	// item held for the duration of the scan
	logic                  cmd_q;
	logic [ID_WIDTH-1:0]   key_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic [LIMIT_W-1:0]    limit_q;

	// scan results
	logic                  match_q;
	logic [IDX_W-1:0]      match_idx_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;

	// read pipeline
	logic                  proc_vld_s1;
	logic [IDX_W-1:0]      proc_idx_s1;
	logic [ID_WIDTH-1:0]   rd_id_s1;
	logic [TIME_WIDTH-1:0] rd_time_s1;

	logic                  out_valid_q;
	logic                  confirmed_q;
	status_t               status_q;

	logic [ID_WIDTH+PORT_ID_W-1:0]    key_ext;
	logic [TIME_WIDTH+PORT_NOW_W-1:0] now_ext;
	logic [ID_WIDTH-1:0]   key_in;
	logic [TIME_WIDTH-1:0] now_in;
	logic [IDX_W-1:0]      rd_addr;
	logic                  entry_vld;
	logic                  hit;
	logic [TIME_WIDTH-1:0] age;
	logic                  too_old;
	logic                  expire;
	logic                  take_free;
	logic                  is_report;
	logic                  do_ref;
	logic                  do_ins;
	logic                  advance_upd;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;
	status_t               status_nxt;

	assign cfg_ready     = 1'b1;
	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign confirmed     = confirmed_q;
	assign report_status = status_q;

	// ids and times resized to the table's widths, zero-extended or truncated
	assign key_ext = {{ID_WIDTH{1'b0}}, ((cmd == CMD_QUERY) ? query_id : mote_id)};
	assign now_ext = {{TIME_WIDTH{1'b0}}, now_us};
	assign key_in  = key_ext[ID_WIDTH-1:0];
	assign now_in  = now_ext[TIME_WIDTH-1:0];

	assign rd_addr = cnt_q[IDX_W-1:0];

	// compare stage on the entry read last cycle
	always_comb begin
		entry_vld = valid_q[proc_idx_s1];
		hit       = proc_vld_s1 && entry_vld && (rd_id_s1 == key_q) && (key_q != '0);
		age       = now_q - rd_time_s1;
		too_old   = {{LIMIT_W{1'b0}}, age} > {{TIME_WIDTH{1'b0}}, limit_q};
		// a matched entry gets refreshed, so its age becomes zero
		expire    = proc_vld_s1 && (cmd_q == CMD_REPORT) && entry_vld && !hit && too_old;
		take_free = proc_vld_s1 && !entry_vld && !free_q;
	end

	// update decision
	always_comb begin
		is_report   = (cmd_q == CMD_REPORT) && (key_q != '0);
		do_ref      = is_report && match_q;
		do_ins      = is_report && !match_q && free_q;
		advance_upd = (state_q == ST_UPD) && (!out_valid_q || out_ready);
		wr_en       = advance_upd && (do_ref || do_ins);
		wr_idx      = match_q ? match_idx_q : free_idx_q;
		priority if (!is_report) begin
			status_nxt = RPT_NONE;
		end else if (match_q) begin
			status_nxt = RPT_REFRESH;
		end else if (free_q) begin
			status_nxt = RPT_INSERT;
		end else begin
			status_nxt = RPT_DROP;
		end
	end

	// memory read port, registered output
	always_ff @(posedge clk) begin
		rd_id_s1   <= id_mem[rd_addr];
		rd_time_s1 <= time_mem[rd_addr];
	end

	// memory write port, only in the update cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[wr_idx] <= now_q;
			if (do_ins) begin
				id_mem[wr_idx] <= key_q;
			end
		end
	end

	// item capture and read pipeline payload
	always_ff @(posedge clk) begin
		proc_idx_s1 <= rd_addr;
		if (in_valid && in_ready) begin
			cmd_q   <= cmd;
			key_q   <= key_in;
			now_q   <= now_in;
			limit_q <= LIMIT_W'(tolerance_ms_q * US_PER_MS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			tolerance_ms_q <= TOL_RESET;
			valid_q        <= '0;
			match_q        <= 1'b0;
			match_idx_q    <= '0;
			free_q         <= 1'b0;
			free_idx_q     <= '0;
			proc_vld_s1    <= 1'b0;
			out_valid_q    <= 1'b0;
			confirmed_q    <= 1'b0;
			status_q       <= RPT_NONE;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tolerance_ms_q <= cfg_data;
			end

			proc_vld_s1 <= (state_q == ST_SCAN) && (cnt_q != CNT_LAST);

			if (hit) begin
				match_q     <= 1'b1;
				match_idx_q <= proc_idx_s1;
			end
			// first free slot as it stood before this item's aging
			if (take_free) begin
				free_q     <= 1'b1;
				free_idx_q <= proc_idx_s1;
			end
			if (expire) begin
				valid_q[proc_idx_s1] <= 1'b0;
			end
			if (advance_upd && do_ins) begin
				valid_q[free_idx_q] <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
						match_q <= 1'b0;
						free_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					// last entry is compared in the cycle the counter reaches the end
					if (cnt_q != CNT_LAST) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (advance_upd) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// output register, refilled only when empty or drained this cycle
			if (advance_upd) begin
				out_valid_q <= 1'b1;
				confirmed_q <= (cmd_q == CMD_QUERY) && match_q;
				status_q    <= status_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sim/aging_id_presence_table_tb.sv
`timescale 1ns / 1ps

module aging_id_presence_table_tb;
	import aip_pkg::*;

	// one result beat as the table should produce it
	typedef struct packed {
		logic    confirmed;
		status_t status;
	} result_t;

	// directed rows: either an item (repeated count times, mote id stepping by one)
	// or a tolerance write
	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        cmd;
		logic [31:0] now;
		logic [15:0] mote;
		logic [15:0] query;
		logic [15:0] tol;
		logic [4:0]  count;
		logic        typed;
		result_t     res;
	} stim_row_t;

	localparam int RAND_PHASES     = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int POOL_SIZE       = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = CMD_REPORT;
	logic [31:0] now_us = '0;
	logic [15:0] mote_id = '0;
	logic [15:0] query_id = '0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        confirmed;
	status_t     report_status;

	// shadow of the table: ids (0 = free), time last heard, tolerance in ms
	logic [15:0] held_id [DEF_ENTRIES];
	logic [31:0] heard_at [DEF_ENTRIES];
	logic [15:0] tol_shadow;

	// results still owed by the dut, oldest first
	result_t pending_results[$];

	// idling switches, changed per phase
	bit in_idle_on  = 1'b1;
	bit out_idle_on = 1'b1;

	int n_errors   = 0;
	int n_items    = 0;
	int n_inserts  = 0;
	int n_refresh  = 0;
	int n_drops    = 0;
	int n_hits     = 0;
	int n_tol_wr   = 0;

	stim_row_t stim_rows[$];

	aging_id_presence_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.now_us       (now_us),
		.mote_id      (mote_id),
		.query_id     (query_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.confirmed    (confirmed),
		.report_status(report_status)
	);

	always #5 clk = ~clk;

	// first slot holding id, -1 if none
	function automatic int find_slot(input logic [15:0] id);
		for (int i = 0; i < DEF_ENTRIES; i++)
			if (held_id[i] == id)
				return i;
		return -1;
	endfunction

	// apply one accepted item to the shadow table and return its result
	function automatic result_t apply_item(input logic c, input logic [31:0] t,
			input logic [15:0] m, input logic [15:0] q);
		result_t     r;
		int          slot;
		logic [31:0] age;
		logic [31:0] limit_us;
		r.confirmed = 1'b0;
		r.status    = RPT_NONE;
		if (c == CMD_QUERY) begin
			// id 0 never confirms even though free slots hold 0
			if (q != '0 && find_slot(q) >= 0)
				r.confirmed = 1'b1;
		end else begin
			limit_us = 32'(tol_shadow) * 32'(US_PER_MS);
			if (m != '0) begin
				slot = find_slot(m);
				if (slot >= 0) begin
					heard_at[slot] = t;
					r.status = RPT_REFRESH;
				end else begin
					slot = find_slot('0);
					if (slot >= 0) begin
						held_id[slot]  = m;
						heard_at[slot] = t;
						r.status = RPT_INSERT;
					end else begin
						r.status = RPT_DROP;
					end
				end
			end
			// aging runs after the update, wrap-around age, strictly greater frees
			for (int i = 0; i < DEF_ENTRIES; i++) begin
				age = t - heard_at[i];
				if (age > limit_us)
					held_id[i] = '0;
			end
		end
		return r;
	endfunction

	// one input beat: idle gap, hold valid until accepted, then predict
	task automatic send_item(input logic c, input logic [31:0] t, input logic [15:0] m,
			input logic [15:0] q, input logic typed, input result_t typed_res);
		int      gap;
		result_t r;
		gap = in_idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		now_us   <= t;
		mote_id  <= m;
		query_id <= q;
		do @(posedge clk); while (!in_ready);
		r = apply_item(c, t, m, q);
		pending_results.push_back(typed ? typed_res : r);
		n_items++;
		case (r.status)
			RPT_INSERT:  n_inserts++;
			RPT_REFRESH: n_refresh++;
			RPT_DROP:    n_drops++;
			default: ;
		endcase
		if (r.confirmed)
			n_hits++;
	endtask

	// tolerance writes only once every owed result has come back
	task automatic write_tolerance(input logic [15:0] v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tol_shadow = v;
		n_tol_wr++;
	endtask

	function automatic void item_row(input logic c, input logic [31:0] t,
			input logic [15:0] m, input logic [15:0] q, input logic [4:0] cnt);
		stim_row_t row;
		row = '0;
		row.kind  = ROW_ITEM;
		row.cmd   = c;
		row.now   = t;
		row.mote  = m;
		row.query = q;
		row.count = cnt;
		stim_rows.push_back(row);
	endfunction

	function automatic void typed_row(input logic c, input logic [31:0] t,
			input logic [15:0] m, input logic [15:0] q, input logic conf, input status_t st);
		stim_row_t row;
		row = '0;
		row.kind          = ROW_ITEM;
		row.cmd           = c;
		row.now           = t;
		row.mote          = m;
		row.query         = q;
		row.count         = 5'd1;
		row.typed         = 1'b1;
		row.res.confirmed = conf;
		row.res.status    = st;
		stim_rows.push_back(row);
	endfunction

	function automatic void cfg_row(input logic [15:0] v);
		stim_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.tol  = v;
		stim_rows.push_back(row);
	endfunction

	// result side: random stall before each beat, compare with the oldest expectation
	initial begin
		int      stall;
		result_t want;
		repeat (12) @(posedge clk);
		forever begin
			stall = out_idle_on ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, confirmed=%0b status=%0d",
					$time, confirmed, report_status);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				if (confirmed !== want.confirmed) begin
					$display("%0t: confirmed mismatch, expected %0b, got %0b",
						$time, want.confirmed, confirmed);
					n_errors++;
				end
				if (report_status !== want.status) begin
					$display("%0t: report_status mismatch, expected %0d, got %0d",
						$time, want.status, report_status);
					n_errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int          k;
		int          j;
		int          phase;
		int          n;
		int          sel;
		logic [15:0] id_pool [POOL_SIZE];
		logic [15:0] phase_tol [RAND_PHASES];
		logic [31:0] t_now;
		logic [31:0] limit_us;
		logic        c;
		logic [15:0] m;
		logic [15:0] q;

		for (k = 0; k < DEF_ENTRIES; k++) begin
			held_id[k]  = '0;
			heard_at[k] = '0;
		end
		tol_shadow = TOL_RESET;

		// default tolerance 250 ms, limit 250000 us
		// empty table: id 0 must not match the free slots
		typed_row(CMD_QUERY, 32'd0, 16'h0000, 16'h0000, 1'b0, RPT_NONE);
		typed_row(CMD_REPORT, 32'd1000, 16'hFFFF, 16'h0000, 1'b0, RPT_INSERT);
		typed_row(CMD_QUERY, 32'd1000, 16'h0000, 16'hFFFF, 1'b1, RPT_NONE);
		typed_row(CMD_REPORT, 32'd2000, 16'hFFFF, 16'hFFFF, 1'b0, RPT_REFRESH);
		// fill the remaining fifteen slots with ids 1..15
		item_row(CMD_REPORT, 32'd3000, 16'h0001, 16'h0000, 5'd15);
		// table full: new id dropped, still aged
		typed_row(CMD_REPORT, 32'd4000, 16'h8000, 16'h0000, 1'b0, RPT_DROP);
		typed_row(CMD_QUERY, 32'd4000, 16'hFFFF, 16'h0000, 1'b0, RPT_NONE);
		// age-only report: 0xffff is 250001 us old and goes, 1..15 stay at 249001
		typed_row(CMD_REPORT, 32'd252001, 16'h0000, 16'hFFFF, 1'b0, RPT_NONE);
		item_row(CMD_QUERY, 32'd252001, 16'hFFFF, 16'hFFFF, 5'd1);
		item_row(CMD_QUERY, 32'd252001, 16'h0000, 16'h000F, 5'd1);
		// time wraps around between these two reports
		item_row(CMD_REPORT, 32'hFFFF_FFF0, 16'hAAAA, 16'h0000, 5'd1);
		item_row(CMD_REPORT, 32'h0000_0010, 16'h5555, 16'h0000, 5'd1);
		item_row(CMD_QUERY, 32'h0000_0010, 16'h0000, 16'hAAAA, 5'd1);
		// zero tolerance: a fresh entry survives its own step, one us later it is gone
		cfg_row(16'd0);
		item_row(CMD_REPORT, 32'h0000_0010, 16'h1234, 16'h0000, 5'd1);
		item_row(CMD_QUERY, 32'h0000_0010, 16'h0000, 16'h1234, 5'd1);
		typed_row(CMD_REPORT, 32'h0000_0011, 16'h0000, 16'h0000, 1'b0, RPT_NONE);
		item_row(CMD_QUERY, 32'h0000_0011, 16'h0000, 16'h5555, 5'd1);
		cfg_row(16'hFFFF);
		item_row(CMD_REPORT, 32'h8000_0000, 16'h7FFF, 16'h0000, 5'd1);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < stim_rows.size(); k++) begin
			if (stim_rows[k].kind == ROW_CFG)
				write_tolerance(stim_rows[k].tol);
			else
				for (j = 0; j < stim_rows[k].count; j++)
					send_item(stim_rows[k].cmd, stim_rows[k].now,
						stim_rows[k].mote + 16'(j), stim_rows[k].query,
						stim_rows[k].typed, stim_rows[k].res);
		end

		// random phases, each with its own tolerance and id pool
		phase_tol[0] = 16'd1;
		phase_tol[1] = 16'($urandom_range(2, 2000));
		phase_tol[2] = 16'hFFFF;
		phase_tol[3] = 16'd0;
		phase_tol[4] = TOL_RESET;
		phase_tol[5] = 16'($urandom_range(0, 5));
		phase_tol[6] = 16'($urandom);
		phase_tol[7] = 16'hFFFF;
		t_now = $urandom;

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			write_tolerance(phase_tol[phase]);
			// idling pattern rotates: both, sender steady, receiver steady, neither
			in_idle_on  = (phase % 4 == 0) || (phase % 4 == 2);
			out_idle_on = (phase % 4 == 0) || (phase % 4 == 1);
			// more ids than slots so the table fills and drops happen
			for (k = 0; k < POOL_SIZE; k++)
				id_pool[k] = 16'($urandom_range(1, 65535));
			limit_us = 32'(tol_shadow) * 32'(US_PER_MS);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// time steps mostly well inside the limit, some right on its edge
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: t_now += $urandom_range(0, limit_us / 6 + 1);
					5:             t_now += limit_us;
					6:             t_now += limit_us + 1;
					7:             ;
					8:             t_now = $urandom;
					default:       t_now += $urandom_range(limit_us, 3 * limit_us + 3);
				endcase
				c = ($urandom_range(0, 9) < 4) ? CMD_QUERY : CMD_REPORT;
				sel = $urandom_range(0, 19);
				if (c == CMD_REPORT) begin
					if (sel < 4)
						m = '0;
					else if (sel < 18)
						m = id_pool[$urandom_range(0, POOL_SIZE - 1)];
					else
						m = 16'($urandom);
					q = 16'($urandom);
				end else begin
					m = 16'($urandom);
					if (sel < 3)
						q = '0;
					else if (sel < 17)
						q = id_pool[$urandom_range(0, POOL_SIZE - 1)];
					else
						q = 16'($urandom);
				end
				send_item(c, t_now, m, q, 1'b0, '0);
			end
		end

		// drain, then watch for stray beats for a while
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			n_errors++;
		end

		$display("%0d items over %0d tolerance settings: %0d inserted, %0d refreshed, %0d dropped",
			n_items, n_tol_wr, n_inserts, n_refresh, n_drops);
		$display("%0d queries confirmed, %0d mismatches", n_hits, n_errors);
		if (n_errors == 0)
			$display("aging_id_presence_table_tb: done, clean");
		else
			$display("aging_id_presence_table_tb: done, errors");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#10_000_000;
		$display("aging_id_presence_table_tb: done, errors");
		$finish;
	end

endmodule
